>>> sv/mrsp_pkg.sv
package mrsp_pkg;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_D1    = 2'd1,
    PH_D2    = 2'd2,
    PH_SYSEX = 2'd3
  } phase_t;

  localparam logic [7:0] ST_REALTIME_LO = 8'hF8;
  localparam logic [7:0] ST_SYSEX_START = 8'hF0;
  localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
  localparam logic [7:0] ST_NONE        = 8'h00;
  localparam logic [7:0] ST_SONG_POS    = 8'hF2;
  localparam logic [7:0] ST_MTC_QF      = 8'hF1;
  localparam logic [7:0] ST_SONG_SEL    = 8'hF3;
  localparam logic [7:0] ST_CHAN_LO     = 8'h80;
  localparam logic [7:0] ST_CHAN2_HI    = 8'hBF;
  localparam logic [7:0] ST_CHAN1_LO    = 8'hC0;
  localparam logic [7:0] ST_CHAN1_HI    = 8'hDF;
  localparam logic [7:0] ST_BEND_LO     = 8'hE0;
  localparam logic [7:0] ST_BEND_HI     = 8'hEF;

  localparam logic [1:0] LEN_ONE   = 2'd1;
  localparam logic [1:0] LEN_TWO   = 2'd2;
  localparam logic [1:0] LEN_THREE = 2'd3;

  // number of data bytes that follow a status byte
  function automatic logic [1:0] data_count(input logic [7:0] s);
    logic [1:0] n;
    n = 2'd0;
    if (s >= ST_CHAN_LO && s <= ST_CHAN2_HI) n = 2'd2;
    else if (s >= ST_CHAN1_LO && s <= ST_CHAN1_HI) n = 2'd1;
    else if (s >= ST_BEND_LO && s <= ST_BEND_HI) n = 2'd2;
    else if (s == ST_MTC_QF || s == ST_SONG_SEL) n = 2'd1;
    else if (s == ST_SONG_POS) n = 2'd2;
    return n;
  endfunction

endpackage

>>> sv/midi_running_status_parser_unit.sv
// MIDI byte-stream parser with running status.
// Input channel: in_valid/in_ready carry one received MIDI byte per word
// (in_byte). Output channel: out_valid/out_ready carry one complete message
// per word: msg_status, msg_channel, first_data, second_data, msg_length.
// A byte is parsed in the cycle it is accepted; the message it closes, if
// any, sits in the output register from the next cycle, so latency is one
// cycle and a new byte may be taken every cycle (one byte per cycle).
// Real-time bytes (F8..FF) go straight through as one-byte messages and
// leave the parse state alone. Bytes that close nothing produce no word.
// in_ready is high while the output register is empty or being emptied in
// the same cycle; when the receiver stalls with a message held, input stalls
// too, and no byte or message is lost.
// Reset (rst, synchronous) empties the output register, returns the parser
// to idle and clears running status, current status and held data.
module midi_running_status_parser_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] msg_status,
  output logic [3:0] msg_channel,
  output logic [6:0] first_data,
  output logic [6:0] second_data,
  output logic [1:0] msg_length
);
  import mrsp_pkg::*;

  phase_t     phase, phase_next;
  logic [7:0] running_status, running_status_next;
  logic [7:0] current_status, current_status_next;
  logic [6:0] held_first_data, held_first_data_next;

  logic       emit;
  logic [7:0] emit_status;
  logic [6:0] emit_d0, emit_d1;
  logic [1:0] emit_len;
  logic       in_fire;
  logic [1:0] rs_count, cs_count;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign rs_count = data_count(running_status);
  assign cs_count = data_count(current_status);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      running_status  <= ST_NONE;
      current_status  <= ST_NONE;
      held_first_data <= '0;
    end else if (in_fire) begin
      phase           <= phase_next;
      running_status  <= running_status_next;
      current_status  <= current_status_next;
      held_first_data <= held_first_data_next;
    end
  end

  always_comb begin
    phase_next           = phase;
    running_status_next  = running_status;
    current_status_next  = current_status;
    held_first_data_next = held_first_data;
    emit        = 1'b0;
    emit_status = in_byte;
    emit_d0     = '0;
    emit_d1     = '0;
    emit_len    = LEN_ONE;
    if (in_byte >= ST_REALTIME_LO) begin
      emit = 1'b1;
    end else if (in_byte == ST_SYSEX_START) begin
      phase_next          = PH_SYSEX;
      current_status_next = ST_SYSEX_START;
      running_status_next = ST_NONE;
    end else if (in_byte == ST_SYSEX_END) begin
      phase_next = PH_IDLE;
    end else if (in_byte[7]) begin
      current_status_next = in_byte;
      running_status_next = in_byte;
      if (data_count(in_byte) == 2'd0) begin
        phase_next = PH_IDLE;
        emit       = 1'b1;
      end else begin
        phase_next = PH_D1;
      end
    end else begin
      unique case (phase)
        PH_IDLE: begin
          // running status: data byte with no fresh status
          if (running_status != ST_NONE && rs_count != 2'd0) begin
            current_status_next = running_status;
            if (rs_count == 2'd1) begin
              emit        = 1'b1;
              emit_status = running_status;
              emit_d0     = in_byte[6:0];
              emit_len    = LEN_TWO;
            end else begin
              held_first_data_next = in_byte[6:0];
              phase_next           = PH_D2;
            end
          end
        end
        PH_D1: begin
          if (cs_count <= 2'd1) begin
            phase_next  = PH_IDLE;
            emit        = 1'b1;
            emit_status = current_status;
            emit_d0     = in_byte[6:0];
            emit_len    = LEN_TWO;
          end else begin
            held_first_data_next = in_byte[6:0];
            phase_next           = PH_D2;
          end
        end
        PH_D2: begin
          phase_next  = PH_IDLE;
          emit        = 1'b1;
          emit_status = current_status;
          emit_d0     = held_first_data;
          emit_d1     = in_byte[6:0];
          emit_len    = LEN_THREE;
        end
        PH_SYSEX: begin
          // SysEx payload is dropped
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      msg_status  <= emit_status;
      msg_channel <= (emit_status >= ST_REALTIME_LO) ? 4'd0 : emit_status[3:0];
      first_data  <= emit_d0;
      second_data <= emit_d1;
      msg_length  <= emit_len;
    end
  end

  a_realtime_passes: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_byte >= ST_REALTIME_LO |=>
      out_valid && msg_length == LEN_ONE && msg_channel == 4'd0)
    else $error("real-time byte not passed through");

  a_sysex_drops: assert property (@(posedge clk) disable iff (rst)
    in_fire && phase == PH_SYSEX && !in_byte[7] |=> !out_valid)
    else $error("data byte inside SysEx produced a message");

  a_d2_needs_two: assert property (@(posedge clk) disable iff (rst)
    phase == PH_D2 |-> cs_count == 2'd2)
    else $error("awaiting second data for a status without two");

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> msg_length != 2'd0)
    else $error("message with zero length");

endmodule
